/* hw/rtl/multi_mode_frame_run_decoder_macros.svh */
// Assertion macros shared by the frame run decoder RTL.
`ifndef MULTI_MODE_FRAME_RUN_DECODER_MACROS_SVH
`define MULTI_MODE_FRAME_RUN_DECODER_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define MMFRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by a result in the next.
`define MMFRD_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) else $error(msg);

`endif

/* hw/rtl/mmfrd_pkg.sv */
// Types, constants and codes of the multi-mode frame run decoder.
`timescale 1ns / 1ps

package mmfrd_pkg;

  localparam int PositionBits = 19;
  localparam int PosW         = 19;
  localparam int GapW         = 10;
  localparam int ByteW        = 8;
  localparam int PalW         = 9;
  localparam int AdvW         = 13;
  localparam int LineWidth    = 640;
  localparam int CopyBack     = 2048;
  localparam int InDataW      = 8;
  localparam int InUserW      = 1;
  localparam int OutUserW     = 2;
  localparam int OutDataW     = 72;
  localparam int OutFieldW    = 65;

  typedef enum logic [2:0] {
    ModeEmpty  = 3'd0,
    ModeType3  = 3'd1,
    ModeType4  = 3'd2,
    ModeType5  = 3'd3,
    ModeType7  = 3'd4,
    ModeTypeFF = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    RegMode  = 2'd0,
    RegStart = 2'd1,
    RegEnd   = 2'd2,
    RegGap   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KindFill = 1'b0,
    KindCopy = 1'b1
  } kind_e;

  typedef struct packed {
    logic               awaiting;
    logic [ByteW-1:0]   held;
    logic [PalW-1:0]    palette;
    logic               finished;
  } ctl_t;

  typedef struct packed {
    logic [GapW-1:0]    line_gap;
    logic [PosW-1:0]    end_pos;
    logic [PosW-1:0]    start_pos;
    logic [2:0]         mode;
  } cfg_t;

  typedef struct packed {
    logic               decode_error;
    logic               frame_done;
    logic [PalW-1:0]    palette_count;
    logic [PosW-1:0]    copy_source;
    logic [ByteW-1:0]   fill_value;
    logic [ByteW-1:0]   run_length;
    logic [PosW-1:0]    run_start;
    logic               write_kind;
    logic               write_valid;
  } res_t;

endpackage

/* hw/rtl/mmfrd_decode.sv */
// Decode of one stream byte into the next decoder state and one result item.
`timescale 1ns / 1ps

module mmfrd_decode #(
  parameter int POSITION_BITS = mmfrd_pkg::PositionBits
) (
  input  mmfrd_pkg::cfg_t            cfg_i,
  input  logic [7:0]                 byte_i,
  input  logic                       frame_start_i,
  input  logic [POSITION_BITS-1:0]   pos_i,
  input  mmfrd_pkg::ctl_t            ctl_i,
  output logic [POSITION_BITS-1:0]   pos_o,
  output mmfrd_pkg::ctl_t            ctl_o,
  output mmfrd_pkg::res_t            res_o
);
  import mmfrd_pkg::*;

  localparam int PW   = POSITION_BITS;
  localparam int SumW = ((PW > AdvW) ? PW : AdvW) + 1;
  localparam int ExtW = (SumW > PosW) ? SumW : PosW;

  logic [ExtW-1:0]  pos_max_ext;
  logic [ExtW-1:0]  start_ext;
  logic [ExtW-1:0]  end_ext;
  logic [PW-1:0]    pos0;
  ctl_t             ctl0;
  logic [ExtW-1:0]  pos0_ext;
  logic [AdvW-1:0]  gap;
  logic             mode_known;
  logic             active;

  logic [AdvW-1:0]  adv;
  logic             hold_en;
  logic             note_en;
  logic [7:0]       note_v;
  logic             fill_en;
  logic [7:0]       fill_v;
  logic [7:0]       fill_n;
  logic             copy_en;
  logic [7:0]       copy_n;
  logic [7:0]       h;
  logic [AdvW-1:0]  v13;
  logic [11:0]      v12;

  logic [ExtW-1:0]  sum_ext;
  logic [ExtW-1:0]  reach_ext;
  logic [ExtW-1:0]  src_ext;
  logic             copy_neg;
  logic [PW-1:0]    pos_next;

  assign pos_max_ext = ExtW'({PW{1'b1}});
  assign start_ext   = ExtW'(cfg_i.start_pos);
  assign end_ext     = ExtW'(cfg_i.end_pos);
  assign gap = ({3'b000, cfg_i.line_gap} > AdvW'(LineWidth)) ? AdvW'(LineWidth)
                                                             : {3'b000, cfg_i.line_gap};

  always_comb begin
    if (frame_start_i) begin
      pos0          = (start_ext > pos_max_ext) ? {PW{1'b1}} : PW'(start_ext);
      ctl0.awaiting = 1'b0;
      ctl0.held     = '0;
      ctl0.palette  = PalW'(1);
      ctl0.finished = 1'b0;
    end else begin
      pos0 = pos_i;
      ctl0 = ctl_i;
    end
  end

  assign pos0_ext   = ExtW'(pos0);
  assign mode_known = (cfg_i.mode >= ModeType3) && (cfg_i.mode <= ModeTypeFF);
  assign active     = mode_known && !ctl0.finished && (pos0_ext < end_ext);
  assign h          = ctl0.held;

  always_comb begin
    adv     = '0;
    hold_en = 1'b0;
    note_en = 1'b0;
    note_v  = '0;
    fill_en = 1'b0;
    fill_v  = '0;
    fill_n  = '0;
    copy_en = 1'b0;
    copy_n  = '0;
    v13     = '0;
    v12     = '0;
    if (active) begin
      unique case (cfg_i.mode)
        ModeType3, ModeType4: begin
          if (ctl0.awaiting) begin
            if (h[7]) begin
              v13 = {h[4:0], byte_i};
              adv = v13[12] ? {1'b0, v13[11:0]} : v13 + AdvW'(2);
            end else begin
              fill_en = 1'b1;
              fill_v  = (cfg_i.mode == ModeType3) ? {5'b0, h[2:0]} : {4'b0, h[3:0]};
              fill_n  = byte_i;
            end
          end else if (byte_i[7]) begin
            if (byte_i[6]) begin
              adv = gap + AdvW'(byte_i[5:0]) + AdvW'(1);
            end else if (byte_i[5]) begin
              hold_en = 1'b1;
            end else begin
              adv = AdvW'(byte_i[5:0]) + AdvW'(2);
            end
          end else begin
            note_en = 1'b1;
            note_v  = (cfg_i.mode == ModeType3) ? {5'b0, byte_i[2:0]} : {4'b0, byte_i[3:0]};
            fill_v  = note_v;
            fill_n  = (cfg_i.mode == ModeType3) ? {3'b0, byte_i[7:3]} : {4'b0, byte_i[7:4]};
            if (fill_n != 8'd0) begin
              fill_en = 1'b1;
            end else begin
              hold_en = 1'b1;
            end
          end
        end
        ModeType5: begin
          if (ctl0.awaiting) begin
            if (h[4:0] == 5'd0) begin
              v12 = {1'b0, h, 3'b000} + {4'b0, byte_i};
              adv = v12[10] ? {3'b000, v12[9:0]} : AdvW'(v12) + AdvW'(2);
            end else begin
              fill_en = 1'b1;
              fill_v  = {3'b0, h[4:0]};
              fill_n  = byte_i;
            end
          end else if (byte_i[4:0] == 5'd0) begin
            hold_en = 1'b1;
          end else begin
            note_en = 1'b1;
            note_v  = {3'b0, byte_i[4:0]};
            fill_v  = note_v;
            fill_n  = {5'b0, byte_i[7:5]};
            if (fill_n != 8'd0) begin
              fill_en = 1'b1;
            end else begin
              hold_en = 1'b1;
            end
          end
        end
        ModeType7: begin
          if (ctl0.awaiting) begin
            if (h[6]) begin
              v12 = {h[3:0], byte_i};
              adv = v12[11] ? {2'b00, v12[10:0]} : AdvW'(v12) + AdvW'(2);
            end else begin
              note_en = 1'b1;
              note_v  = byte_i;
              fill_en = 1'b1;
              fill_v  = byte_i;
              fill_n  = {2'b0, h[5:0]};
            end
          end else if (byte_i[7]) begin
            if (byte_i[6]) begin
              if (byte_i[5]) begin
                adv = gap + AdvW'(byte_i[4:0]) + AdvW'(1);
              end else if (byte_i[4]) begin
                hold_en = 1'b1;
              end else begin
                adv = AdvW'(byte_i[4:0]) + AdvW'(2);
              end
            end else begin
              hold_en = 1'b1;
            end
          end else begin
            note_en = 1'b1;
            note_v  = byte_i;
            fill_en = 1'b1;
            fill_v  = byte_i;
            fill_n  = 8'd1;
          end
        end
        ModeTypeFF: begin
          if (ctl0.awaiting) begin
            if (h < 8'he0) begin
              copy_en = 1'b1;
              copy_n  = {4'b0, h[6:3]} + 8'd3;
              adv     = AdvW'(copy_n);
            end else if (h < 8'hf0) begin
              note_en = 1'b1;
              note_v  = byte_i;
              fill_en = 1'b1;
              fill_v  = byte_i;
              fill_n  = {4'b0, h[3:0]} + 8'd1;
            end else begin
              adv = {1'b0, h[3:0], byte_i};
            end
          end else if (byte_i < 8'h80) begin
            note_en = 1'b1;
            note_v  = byte_i;
            fill_en = 1'b1;
            fill_v  = byte_i;
            fill_n  = 8'd1;
          end else begin
            hold_en = 1'b1;
          end
        end
        default: begin
          adv = '0;
        end
      endcase
      if (fill_en) begin
        adv = AdvW'(fill_n);
      end
    end
  end

  assign sum_ext   = pos0_ext + ExtW'(adv);
  assign pos_next  = (sum_ext > pos_max_ext) ? {PW{1'b1}} : sum_ext[PW-1:0];
  assign reach_ext = pos0_ext + ExtW'({h[2:0], byte_i});
  assign copy_neg  = reach_ext < ExtW'(CopyBack);
  assign src_ext   = reach_ext - ExtW'(CopyBack);
  assign pos_o     = pos_next;

  always_comb begin
    ctl_o = ctl0;
    if (!mode_known) begin
      ctl_o.awaiting = 1'b0;
    end else if (active) begin
      ctl_o.awaiting = hold_en;
      if (hold_en) begin
        ctl_o.held = byte_i;
      end
    end
    if (note_en && (ctl0.palette <= PalW'(note_v))) begin
      ctl_o.palette = PalW'(note_v) + PalW'(1);
    end
    if (ExtW'(pos_next) >= end_ext) begin
      ctl_o.finished = 1'b1;
    end
  end

  always_comb begin
    res_o = '0;
    if (fill_en && (fill_n != 8'd0)) begin
      res_o.write_valid = 1'b1;
      res_o.write_kind  = KindFill;
      res_o.run_start   = pos0_ext[PosW-1:0];
      res_o.run_length  = fill_n;
      res_o.fill_value  = fill_v;
    end else if (copy_en && !copy_neg) begin
      res_o.write_valid = 1'b1;
      res_o.write_kind  = KindCopy;
      res_o.run_start   = pos0_ext[PosW-1:0];
      res_o.run_length  = copy_n;
      res_o.copy_source = src_ext[PosW-1:0];
    end
    res_o.palette_count = ctl_o.palette;
    res_o.frame_done    = ctl_o.finished;
    res_o.decode_error  = (cfg_i.mode > ModeTypeFF) || (copy_en && copy_neg);
  end

endmodule

/* hw/rtl/multi_mode_frame_run_decoder.sv */
// Top level of the multi-mode frame run decoder: stream ports, registers and pipeline.
`timescale 1ns / 1ps

// The decoder takes one byte of a compressed indexed frame per item and gives one result
// item per byte, with a fill or copy command when the byte completes one. An item is
// accepted in every cycle when the output side keeps up. An accepted byte is captured in
// the input register and decoded from there into the output register, which presents
// its result and holds it until it is taken. A result that is not taken holds the input
// register, which then stalls the input side. The rate is set by the combinational
// decode between the input register and the decoder state. Configuration must be
// written only while no item is in flight; the block itself does not enforce this.
`include "multi_mode_frame_run_decoder_macros.svh"

module multi_mode_frame_run_decoder #(
  parameter int POSITION_BITS = mmfrd_pkg::PositionBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [mmfrd_pkg::PosW-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: data_byte.
  input  logic [mmfrd_pkg::InDataW-1:0]  s_axis_tdata,
  // Fields from bit 0: frame_start.
  input  logic [mmfrd_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: run_start, run_length, fill_value, copy_source, palette_count,
  // frame_done, decode_error, zero padding.
  output logic [mmfrd_pkg::OutDataW-1:0] m_axis_tdata,
  // Fields from bit 0: write_valid, write_kind.
  output logic [mmfrd_pkg::OutUserW-1:0] m_axis_tuser
);
  import mmfrd_pkg::*;

  cfg_t                      cfg_q;
  logic                      in_vld_q;
  logic [7:0]                in_byte_q;
  logic                      in_fs_q;
  logic [POSITION_BITS-1:0]  pos_q;
  logic [POSITION_BITS-1:0]  pos_d;
  ctl_t                      ctl_q;
  ctl_t                      ctl_d;
  res_t                      res_d;
  res_t                      res_q;
  logic                      out_vld_q;
  logic                      step;
  logic                      out_write;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMode:  cfg_q.mode      <= cfg_data_i[2:0];
        RegStart: cfg_q.start_pos <= cfg_data_i;
        RegEnd:   cfg_q.end_pos   <= cfg_data_i;
        RegGap:   cfg_q.line_gap  <= cfg_data_i[GapW-1:0];
        default:  cfg_q           <= cfg_q;
      endcase
    end
  end

  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_fs_q   <= s_axis_tuser[0];
    end
  end

  mmfrd_decode #(
    .POSITION_BITS(POSITION_BITS)
  ) u_decode (
    .cfg_i         (cfg_q),
    .byte_i        (in_byte_q),
    .frame_start_i (in_fs_q),
    .pos_i         (pos_q),
    .ctl_i         (ctl_q),
    .pos_o         (pos_d),
    .ctl_o         (ctl_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q            <= '0;
      ctl_q.awaiting   <= 1'b0;
      ctl_q.held       <= '0;
      ctl_q.palette    <= PalW'(1);
      ctl_q.finished   <= 1'b0;
      out_vld_q        <= 1'b0;
    end else if (step) begin
      pos_q     <= pos_d;
      ctl_q     <= ctl_d;
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {res_q.write_kind, res_q.write_valid};
  assign m_axis_tdata  = {{(OutDataW - OutFieldW){1'b0}},
                          res_q.decode_error, res_q.frame_done, res_q.palette_count,
                          res_q.copy_source, res_q.fill_value, res_q.run_length,
                          res_q.run_start};

  assign out_write = m_axis_tvalid && res_q.write_valid;

  `MMFRD_ASSERT(a_palette_nonzero, ctl_q.palette != '0, "Palette count dropped to zero.")
  `MMFRD_ASSERT_NEXT(a_step_gives_result, step, m_axis_tvalid, "Decoded item not presented.")
  `MMFRD_ASSERT(a_write_has_length, !out_write || (res_q.run_length != '0), "Zero-length write.")
  `MMFRD_ASSERT(a_error_no_write, !out_write || !res_q.decode_error, "Write with an error flag.")

endmodule
